>>> sv/csam_pkg.sv
// shared types and constants for the class score argmax/margin block
// no dependencies; imported by every module of the block
package csam_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int CLS_W       = 4;
  localparam int CNT_W       = 5;
  localparam int SCORE_W     = 16;
  localparam int RES_W       = 20;
  localparam int QUAL_W      = 19;
  localparam int THR_W       = 20;
  localparam int DIFF_W      = SCORE_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [QUAL_W-1:0]       QUALITY_CAP = QUAL_W'(409600);
  localparam logic signed [THR_W-1:0] THR_RESET   = THR_W'(409);

  localparam logic CMD_SCORE = 1'b0;
  localparam logic CMD_THR   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_LO  = 3'd0,
    CFG_OUT_HI  = 3'd1,
    CFG_WANT_LO = 3'd2,
    CFG_WANT_HI = 3'd3,
    CFG_ALIGN   = 3'd4,
    CFG_COUNT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [SCORE_W-1:0] score;
    logic                     last_score;
    logic [CLS_W-1:0]         class_index;
    logic signed [THR_W-1:0]  threshold_value;
  } csam_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] scaled_score;
    logic [CLS_W-1:0]        out_index;
    logic                    last_result;
    logic [CLS_W-1:0]        winner;
    logic [QUAL_W-1:0]       quality;
    logic                    success;
  } csam_out_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] out_lo;
    logic signed [SCORE_W-1:0] out_hi;
    logic signed [SCORE_W-1:0] want_lo;
    logic signed [SCORE_W-1:0] want_hi;
    logic                      align;
    logic [CNT_W-1:0]          count;
  } csam_cfg_t;

  typedef enum logic {
    Q_THR = 1'b0,
    Q_RUN = 1'b1
  } qkind_t;

  typedef struct packed {
    qkind_t                    kind;
    logic [CLS_W-1:0]          idx;
    logic signed [THR_W-1:0]   thr;
    logic [CNT_W-1:0]          count;
    logic signed [SCORE_W-1:0] vmax;
    logic signed [SCORE_W-1:0] vmin;
  } csam_qent_t;

endpackage

>>> sv/class_score_argmax_margin.sv
// top level of the class score argmax/margin block: config registers and wiring
// depends on csam_pkg, csam_front, csam_fifo, csam_back (and csam_div below it)
//
// Scores of one vector arrive one item per class (cmd 0), the last one marked;
// the front end stores them at one item per cycle when ready, tracks min/max.
// Threshold writes (cmd 1) travel through the same two-entry queue, so they
// take effect in item order. At a vector end the back end walks the stored
// scores: optional min/max stretch onto the output range, then a linear map
// from the output range onto the wanted range, each a 17x17 multiply and a
// rounded divide in a shared one-bit-per-cycle divider. A zero output span
// skips the map, and a class waits on any output stall. Results leave in
// class order; the last one carries winner, quality and success.
// While a vector is being worked off, new score items wait; threshold writes
// keep flowing until the queue is full.
module class_score_argmax_margin (
  input  logic                             clk,
  input  logic                             rst_n,
  input  csam_pkg::csam_in_t               in_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  output csam_pkg::csam_out_t              out_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  logic [csam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csam_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);
  import csam_pkg::*;

  csam_cfg_t                 cfg_r;
  csam_qent_t                fq_data, bq_data;
  logic                      fq_valid, fq_ready, bq_valid, bq_ready;
  logic                      run_done;
  logic [CLS_W-1:0]          rd_idx;
  logic signed [SCORE_W-1:0] rd_data;

  // config writes are always taken, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_lo  <= -SCORE_W'(2048);
      cfg_r.out_hi  <= SCORE_W'(2048);
      cfg_r.want_lo <= -SCORE_W'(2048);
      cfg_r.want_hi <= SCORE_W'(2048);
      cfg_r.align   <= 1'b0;
      cfg_r.count   <= CNT_W'(10);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OUT_LO:  cfg_r.out_lo  <= cfg_data;
        CFG_OUT_HI:  cfg_r.out_hi  <= cfg_data;
        CFG_WANT_LO: cfg_r.want_lo <= cfg_data;
        CFG_WANT_HI: cfg_r.want_hi <= cfg_data;
        CFG_ALIGN:   cfg_r.align   <= cfg_data[0];
        CFG_COUNT:   cfg_r.count   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: score loading, extremes, vector end detection
  csam_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .class_count (cfg_r.count),
    .q_data      (fq_data),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .run_done    (run_done),
    .rd_idx      (rd_idx),
    .rd_data     (rd_data)
  );

  // queue of threshold writes and vector runs
  csam_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (fq_data),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .rd_data  (bq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready)
  );

  // back: per-class arithmetic, winner/margin, result register
  csam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_data    (bq_data),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .run_done  (run_done),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

`ifndef ASSERT_OFF
  // quality never exceeds the cap on a final result
  a_qual_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> out_data.quality <= QUALITY_CAP)
    else $error("quality above cap");

  // summary fields are zero on results that are not final
  a_nonfinal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |->
      out_data.winner == '0 && out_data.quality == '0 && !out_data.success)
    else $error("summary on non-final result");

  // the winner is one of the classes already emitted
  a_winner_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |-> out_data.winner <= out_data.out_index)
    else $error("winner beyond last class");
`endif

endmodule

>>> sv/csam_front.sv
// front end: accepts items, loads the score store and tracks min/max
// depends on csam_pkg
module csam_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csam_pkg::csam_in_t          in_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [csam_pkg::CNT_W-1:0]  class_count,
  output csam_pkg::csam_qent_t        q_data,
  output logic                        q_valid,
  input  logic                        q_ready,
  input  logic                        run_done,
  input  logic [csam_pkg::CLS_W-1:0]  rd_idx,
  output logic signed [csam_pkg::SCORE_W-1:0] rd_data
);
  import csam_pkg::*;

  logic signed [SCORE_W-1:0] store_r [MAX_CLASSES];
  logic [CNT_W-1:0]          cnt_r, cnt_nxt, eff;
  logic signed [SCORE_W-1:0] max_r, max_nxt, min_r, min_nxt;
  logic                      busy_r;
  logic                      is_thr, acc, take;

  always_comb begin
    if (class_count == '0) begin
      eff = CNT_W'(1);
    end else if (class_count > CNT_W'(MAX_CLASSES)) begin
      eff = CNT_W'(MAX_CLASSES);
    end else begin
      eff = class_count;
    end
  end

  assign is_thr   = (in_data.cmd == CMD_THR);
  // score items wait until the back end has drained the store
  assign in_ready = q_ready && (is_thr || !busy_r);
  assign acc      = in_valid && in_ready;
  assign take     = acc && !is_thr && (cnt_r < eff);

  always_comb begin
    cnt_nxt = cnt_r;
    max_nxt = max_r;
    min_nxt = min_r;
    if (take) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == '0 || in_data.score > max_r) max_nxt = in_data.score;
      if (cnt_r == '0 || in_data.score < min_r) min_nxt = in_data.score;
    end
  end

  assign q_valid       = acc && (is_thr || in_data.last_score);
  assign q_data.kind   = is_thr ? Q_THR : Q_RUN;
  assign q_data.idx    = in_data.class_index;
  assign q_data.thr    = in_data.threshold_value;
  assign q_data.count  = cnt_nxt;
  assign q_data.vmax   = max_nxt;
  assign q_data.vmin   = min_nxt;

  assign rd_data = store_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      if (acc && !is_thr && in_data.last_score) begin
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else begin
        cnt_r <= cnt_nxt;
        if (run_done) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
    min_r <= min_nxt;
    if (take) store_r[cnt_r[CLS_W-1:0]] <= in_data.score;
  end

endmodule

>>> sv/csam_fifo.sv
// two-entry queue between front and back ends
// depends on csam_pkg
module csam_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csam_pkg::csam_qent_t wr_data,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  output csam_pkg::csam_qent_t rd_data,
  output logic                 rd_valid,
  input  logic                 rd_ready
);
  import csam_pkg::*;

  csam_qent_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       wr, rd;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      if (wr && !rd) fill_r <= fill_r + 2'd1;
      else if (rd && !wr) fill_r <= fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> sv/csam_div.sv
// shared divider, one quotient bit per cycle, round to nearest, ties away
// depends on csam_pkg
module csam_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [csam_pkg::PROD_W-1:0]  num,
  input  logic signed [csam_pkg::DIFF_W-1:0]  den,
  output logic                                done,
  output logic signed [csam_pkg::PROD_W:0]    quot
);
  import csam_pkg::*;

  localparam int STEP_W = $clog2(PROD_W + 1);

  logic [PROD_W-1:0] n_r, na;
  logic [DIFF_W-1:0] d_r, dm, rem_r;
  logic [DIFF_W:0]   trial;
  logic              neg_r, done_r, ge;
  logic [STEP_W-1:0] step_r;

  assign na    = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
  assign dm    = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
  assign trial = {rem_r, n_r[PROD_W-1]};
  assign ge    = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      // done pulses after the last quotient bit
      done_r <= !start && (step_r == STEP_W'(1));
      if (start) begin
        n_r    <= na + PROD_W'(dm >> 1);
        d_r    <= dm;
        rem_r  <= '0;
        neg_r  <= num[PROD_W-1] ^ den[DIFF_W-1];
        step_r <= STEP_W'(PROD_W);
      end else if (step_r != '0) begin
        rem_r  <= ge ? DIFF_W'(trial - {1'b0, d_r}) : trial[DIFF_W-1:0];
        n_r    <= {n_r[PROD_W-2:0], ge};
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, n_r}) : $signed({1'b0, n_r});

endmodule

>>> sv/csam_back.sv
// back end: thresholds, align/scale per class, winner and margin tracking
// depends on csam_pkg and csam_div
module csam_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csam_pkg::csam_cfg_t          cfg,
  input  csam_pkg::csam_qent_t         q_data,
  input  logic                         q_valid,
  output logic                         q_ready,
  output logic [csam_pkg::CLS_W-1:0]   rd_idx,
  input  logic signed [csam_pkg::SCORE_W-1:0] rd_data,
  output logic                         run_done,
  output csam_pkg::csam_out_t          out_data,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import csam_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_AMUL, S_AGO, S_AWAIT, S_SMUL, S_SGO, S_SWAIT, S_EMIT
  } state_t;

  localparam logic signed [PROD_W+1:0] SAT_HI = (PROD_W+2)'(524287);
  localparam logic signed [PROD_W+1:0] SAT_LO = -(PROD_W+2)'(524288);

  state_t                    state_r;
  logic [CNT_W-1:0]          n_r, k_r;
  logic signed [SCORE_W-1:0] min_r;
  logic signed [DIFF_W-1:0]  dspan_r, v_r;
  logic                      align_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [RES_W-1:0]   res_r;
  logic signed [THR_W-1:0]   thr_r [MAX_CLASSES];
  logic signed [RES_W-1:0]   best_r, second_r, best_nxt, second_nxt;
  logic [CLS_W-1:0]          bidx_r, bidx_nxt;
  logic                      have2_r, have2_nxt;
  csam_out_t                 out_r;
  logic                      out_valid_r, done_r;

  logic signed [DIFF_W-1:0]  ospan, wspan;
  logic                      div_start, div_done;
  logic signed [PROD_W-1:0]  div_num;
  logic signed [DIFF_W-1:0]  div_den;
  logic signed [PROD_W:0]    quot;
  logic signed [PROD_W:0]    asum;
  logic signed [PROD_W+1:0]  ssum;
  logic signed [RES_W:0]     margin;
  logic [QUAL_W-1:0]         qual;
  logic signed [THR_W-1:0]   wthr;
  logic                      fin, ok, slot;

  assign ospan = DIFF_W'(cfg.out_hi) - DIFF_W'(cfg.out_lo);
  assign wspan = DIFF_W'(cfg.want_hi) - DIFF_W'(cfg.want_lo);

  assign div_start = (state_r == S_AGO) || (state_r == S_SGO);
  assign div_num   = prod_r;
  assign div_den   = (state_r == S_AGO) ? dspan_r : ospan;

  csam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign asum = quot + (PROD_W+1)'(cfg.out_lo);
  assign ssum = (PROD_W+2)'(quot) + (PROD_W+2)'(cfg.want_lo);

  // running first maximum and runner-up
  always_comb begin
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    second_nxt = second_r;
    have2_nxt  = have2_r;
    if (k_r == '0) begin
      best_nxt  = res_r;
      bidx_nxt  = '0;
      have2_nxt = 1'b0;
    end else if (res_r > best_r) begin
      second_nxt = best_r;
      have2_nxt  = 1'b1;
      best_nxt   = res_r;
      bidx_nxt   = k_r[CLS_W-1:0];
    end else if (!have2_r || res_r > second_r) begin
      second_nxt = res_r;
      have2_nxt  = 1'b1;
    end
  end

  assign margin = (RES_W+1)'(best_nxt) - (RES_W+1)'(second_nxt);
  assign qual   = (!have2_nxt || margin > $signed({2'b00, QUALITY_CAP})) ? QUALITY_CAP
                : margin[QUAL_W-1:0];
  assign wthr   = thr_r[bidx_nxt];
  assign ok     = (wthr > 0) && ((RES_W+1)'(wthr) < $signed({2'b00, qual}));
  assign fin    = (k_r + CNT_W'(1) == n_r);
  assign slot   = !out_valid_r || out_ready;

  assign q_ready   = (state_r == S_IDLE);
  assign rd_idx    = k_r[CLS_W-1:0];
  assign run_done  = done_r;
  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) thr_r[i] <= THR_RESET;
    end else begin
      done_r <= (state_r == S_EMIT) && slot && fin;
      if (state_r == S_EMIT && slot) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.kind == Q_THR) begin
              thr_r[q_data.idx] <= q_data.thr;
            end else begin
              n_r     <= q_data.count;
              k_r     <= '0;
              min_r   <= q_data.vmin;
              dspan_r <= DIFF_W'(q_data.vmax) - DIFF_W'(q_data.vmin);
              align_r <= cfg.align && (q_data.vmax != '0) && (q_data.vmax != q_data.vmin);
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          v_r     <= DIFF_W'(rd_data);
          state_r <= align_r ? S_AMUL : S_SMUL;
        end
        S_AMUL: begin
          prod_r  <= (v_r - DIFF_W'(min_r)) * ospan;
          state_r <= S_AGO;
        end
        S_AGO: state_r <= S_AWAIT;
        S_AWAIT: begin
          if (div_done) begin
            v_r     <= asum[DIFF_W-1:0];
            state_r <= S_SMUL;
          end
        end
        S_SMUL: begin
          if (ospan != '0) begin
            prod_r  <= (v_r - DIFF_W'(cfg.out_lo)) * wspan;
            state_r <= S_SGO;
          end else begin
            res_r   <= RES_W'(v_r);
            state_r <= S_EMIT;
          end
        end
        S_SGO: state_r <= S_SWAIT;
        S_SWAIT: begin
          if (div_done) begin
            if (ssum > SAT_HI) res_r <= RES_W'(SAT_HI);
            else if (ssum < SAT_LO) res_r <= RES_W'(SAT_LO);
            else res_r <= ssum[RES_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot) begin
            out_r.scaled_score <= res_r;
            out_r.out_index    <= k_r[CLS_W-1:0];
            out_r.last_result  <= fin;
            out_r.winner       <= fin ? bidx_nxt : '0;
            out_r.quality      <= fin ? qual : '0;
            out_r.success      <= fin && ok;
            best_r   <= best_nxt;
            bidx_r   <= bidx_nxt;
            second_r <= second_nxt;
            have2_r  <= have2_nxt;
            k_r      <= k_r + CNT_W'(1);
            if (fin) begin
              state_r <= S_IDLE;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> test/class_score_argmax_margin_tb.sv
// self-checking testbench for class_score_argmax_margin: directed and random score vectors
// depends on csam_pkg and the class_score_argmax_margin rtl
module class_score_argmax_margin_tb;
  import csam_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  csam_in_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  csam_out_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  class_score_argmax_margin dut (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: register copies and block memories
  longint m_out_lo, m_out_hi, m_want_lo, m_want_hi;
  bit     m_align;
  int     m_count;
  longint m_scores[MAX_CLASSES];
  longint m_thr[MAX_CLASSES];
  int     m_loaded;
  longint m_max, m_min;

  csam_in_t  pend_q[$];     // items waiting for the driver
  csam_out_t scaled_q[$];   // expected results in order
  int n_pushed = 0;
  int n_taken = 0;
  int errors = 0;
  logic in_fire = 1'b0;
  bit quiet = 1'b0;         // no idling on either side while set

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(0, 99) < 21);
  endfunction

  // rounded divide, ties away from zero
  function automatic longint rdiv(longint num, longint den);
    longint n, d, q;
    bit neg;
    neg = (num < 0) ^ (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n + d / 2) / d;
    return neg ? -q : q;
  endfunction

  function automatic longint clip20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // update model for one accepted item, queue the results it causes
  task automatic predict_scores(csam_in_t it);
    longint v[MAX_CLASSES];
    longint span, q;
    int eff, n, w;
    bit ok;
    csam_out_t r;
    if (it.cmd == CMD_THR) begin
      m_thr[it.class_index] = longint'(it.threshold_value);
      return;
    end
    eff = (m_count == 0) ? 1 : (m_count > MAX_CLASSES ? MAX_CLASSES : m_count);
    if (m_loaded < eff) begin
      m_scores[m_loaded] = longint'(it.score);
      if (m_loaded == 0 || longint'(it.score) > m_max) m_max = longint'(it.score);
      if (m_loaded == 0 || longint'(it.score) < m_min) m_min = longint'(it.score);
      m_loaded++;
    end
    if (!it.last_score) return;
    n = m_loaded;
    m_loaded = 0;
    for (int k = 0; k < n; k++) v[k] = m_scores[k];
    // min/max stretch onto the output range
    if (m_align && m_max != 0 && m_max != m_min)
      for (int k = 0; k < n; k++)
        v[k] = rdiv((v[k] - m_min) * (m_out_hi - m_out_lo), m_max - m_min) + m_out_lo;
    span = m_out_hi - m_out_lo;
    for (int k = 0; k < n; k++) begin
      if (span != 0)
        v[k] = rdiv((v[k] - m_out_lo) * (m_want_hi - m_want_lo), span) + m_want_lo;
      v[k] = clip20(v[k]);
    end
    w = 0;
    for (int k = 1; k < n; k++) if (v[k] > v[w]) w = k;
    q = 409600;
    for (int k = 0; k < n; k++) if (k != w && v[w] - v[k] < q) q = v[w] - v[k];
    ok = (m_thr[w] > 0) && (m_thr[w] < q);
    for (int k = 0; k < n; k++) begin
      r = '0;
      r.scaled_score = v[k][RES_W-1:0];
      r.out_index = k[CLS_W-1:0];
      r.last_result = (k == n - 1);
      if (k == n - 1) begin
        r.winner = w[CLS_W-1:0];
        r.quality = q[QUAL_W-1:0];
        r.success = ok;
      end
      scaled_q.push_back(r);
    end
  endtask

  // predictor and result checker, both at the rising edge
  always @(posedge clk) begin
    csam_out_t e;
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_scores(in_data);
      n_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = scaled_q.pop_front();
        if (e.scaled_score !== out_data.scaled_score || e.out_index !== out_data.out_index ||
            e.last_result !== out_data.last_result || e.winner !== out_data.winner ||
            e.quality !== out_data.quality || e.success !== out_data.success) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  // item driver, fed from pend_q
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pend_q.size() > 0 && !idle_roll()) begin
          in_data <= pend_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !idle_roll();
    end
  end

  task automatic push_thr(int idx, longint val);
    csam_in_t it;
    it = '0;
    it.cmd = CMD_THR;
    it.class_index = idx[CLS_W-1:0];
    it.threshold_value = val[THR_W-1:0];
    it.score = $urandom();
    pend_q.push_back(it);
    n_pushed++;
  endtask

  task automatic push_score(longint s, bit last);
    csam_in_t it;
    it = '0;
    it.cmd = CMD_SCORE;
    it.score = s[SCORE_W-1:0];
    it.last_score = last;
    it.class_index = $urandom();
    it.threshold_value = $urandom();
    pend_q.push_back(it);
    n_pushed++;
  endtask

  task automatic write_reg(cfg_idx_t idx, longint val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OUT_LO:  m_out_lo = longint'($signed(val[15:0]));
      CFG_OUT_HI:  m_out_hi = longint'($signed(val[15:0]));
      CFG_WANT_LO: m_want_lo = longint'($signed(val[15:0]));
      CFG_WANT_HI: m_want_hi = longint'($signed(val[15:0]));
      CFG_ALIGN:   m_align = val[0];
      CFG_COUNT:   m_count = int'(val[4:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(longint olo, longint ohi, longint wlo, longint whi, bit al, int cnt);
    write_reg(CFG_OUT_LO, olo);
    write_reg(CFG_OUT_HI, ohi);
    write_reg(CFG_WANT_LO, wlo);
    write_reg(CFG_WANT_HI, whi);
    write_reg(CFG_ALIGN, al);
    write_reg(CFG_COUNT, cnt);
  endtask

  // every item taken and every result seen, then let the back end run dry
  task automatic drain();
    do @(posedge clk); while (n_taken != n_pushed || scaled_q.size() != 0);
    repeat (2000) @(posedge clk);
  endtask

  function automatic longint rand_s16();
    return longint'($signed(16'($urandom())));
  endfunction

  initial begin
    int cnt, len, eff;
    longint lo, hi;
    m_out_lo = -2048; m_out_hi = 2048; m_want_lo = -2048; m_want_hi = 2048;
    m_align = 0; m_count = 10; m_loaded = 0; m_max = 0; m_min = 0;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      m_scores[i] = 0;
      m_thr[i] = 409;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, threshold extremes, score extremes, short and long vectors
    set_regs(-2048, 2048, -2048, 2048, 0, 10);
    push_thr(0, 524287);
    push_thr(15, -524288);
    push_thr(3, 0);
    push_thr(1, 100);
    for (int k = 0; k < 10; k++) push_score(k[0] ? 32767 : -32768 + k, k == 9);
    push_score(100, 0); push_score(-100, 0); push_score(50, 1);
    for (int k = 0; k < 12; k++) push_score(k * 300 - 1500, k == 11);
    drain();

    // alignment skipped for a zero maximum and for a flat vector, then applied
    set_regs(-4096, 4096, 0, 8192, 1, 4);
    push_score(-5, 0); push_score(-100, 0); push_score(0, 0); push_score(-7, 1);
    for (int k = 0; k < 4; k++) push_score(7, k == 3);
    push_score(1000, 0); push_score(-3000, 0); push_score(250, 0); push_score(999, 1);
    drain();

    // zero output span, full vector
    set_regs(100, 100, -2048, 2048, 0, 16);
    for (int k = 0; k < 16; k++) push_score(rand_s16(), k == 15);
    drain();

    // single class, then a count of zero
    set_regs(-2048, 2048, -2048, 2048, 0, 1);
    push_score(1234, 0); push_score(-9, 1);
    drain();
    write_reg(CFG_COUNT, 0);
    push_score(-32768, 1);
    drain();

    // count above the class limit, extreme and inverted ranges, saturation
    quiet = 1'b1;
    set_regs(-32768, 32767, 32767, -32768, 1, 31);
    for (int k = 0; k < 17; k++) push_score(rand_s16(), k == 16);
    drain();
    quiet = 1'b0;

    // random phases: mostly well-formed vectors, some short or long, threshold writes mixed in
    for (int p = 0; p < 10; p++) begin
      cnt = (p % 3 == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
      if (p == 9) cnt = 16;
      if ($urandom_range(0, 3) == 0) begin
        lo = rand_s16(); hi = rand_s16();
      end else begin
        lo = -$urandom_range(0, 8192); hi = $urandom_range(1, 8192);
      end
      set_regs(lo, hi, -$urandom_range(0, 16384), $urandom_range(0, 16384),
               $urandom_range(0, 1), cnt);
      eff = (cnt == 0) ? 1 : (cnt > 16 ? 16 : cnt);
      while (n_pushed < 60 + 31 * (p + 1)) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 1)) push_thr($urandom_range(0, 15), longint'($signed(20'($urandom()))));
          else push_thr($urandom_range(0, 15), $urandom_range(0, 30000));
        end else begin
          len = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 17) : eff;
          for (int k = 0; k < len; k++)
            push_score($urandom_range(0, 1) ? rand_s16() : lo + $urandom_range(0, 8192),
                       k == len - 1);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // generous limit on the whole run
  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

endmodule
